// ===== sv/aesbc_pkg.sv =====
// ============================================================================
// AES block cipher package
// Shared tables, constants, types and round functions for the AES core.
// ============================================================================
package aesbc_pkg;

   localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] REG_IV_HIGH    = 3'd4;
   localparam logic [2:0] REG_IV_LOW     = 3'd5;
   localparam logic [2:0] REG_KEY_LENGTH = 3'd6;
   localparam logic [2:0] REG_CHAINING   = 3'd7;

   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1B;

   typedef struct packed {
      logic load;
      logic add_key;
      logic round;
      logic skip_mix;
      logic finish;
   } ctrl_cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic skip_mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] o;
      for (int k = 0; k < 16; k++) b[k] = s[127 - 8 * k -: 8];
      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 4; k++) t[k + 4 * c] = SBOX[b[k + 4 * ((c + k) & 3)]];
      if (!skip_mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
      end
      for (int k = 0; k < 16; k++) o[127 - 8 * k -: 8] = t[k];
      enc_round = o ^ rk;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      for (int j = 0; j < 4; j++) begin
         a[j]  = col[31 - 8 * j -: 8];
         m2[j] = xtime(a[j]);
         m4[j] = xtime(m2[j]);
         m8[j] = xtime(m4[j]);
         m9[j] = m8[j] ^ a[j];
         mb[j] = m8[j] ^ m2[j] ^ a[j];
         md[j] = m8[j] ^ m4[j] ^ a[j];
         me[j] = m8[j] ^ m4[j] ^ m2[j];
      end
      inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                     m9[0] ^ me[1] ^ mb[2] ^ md[3],
                     md[0] ^ m9[1] ^ me[2] ^ mb[3],
                     mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic skip_mix);
      logic [127:0] m;
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [127:0] o;
      m = s;
      if (!skip_mix) begin
         for (int c = 0; c < 4; c++) m[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
      end
      for (int k = 0; k < 16; k++) b[k] = m[127 - 8 * k -: 8];
      for (int c = 0; c < 4; c++)
         for (int k = 0; k < 4; k++) t[k + 4 * ((c + k) & 3)] = b[k + 4 * c];
      for (int k = 0; k < 16; k++) o[127 - 8 * k -: 8] = INV_SBOX[t[k]];
      dec_round = o ^ rk;
   endfunction

endpackage

// ===== sv/aesbc_key_sched.sv =====
// ============================================================================
// AES key schedule
// Expands the key one 32-bit word per cycle into the round key memory and
// serves one registered round key read per cycle.
// ============================================================================
module aesbc_key_sched #(
   parameter int MAX_ROUND_KEYS = 15,
   localparam int KIDX_W = $clog2(MAX_ROUND_KEYS),
   localparam int WIDX_W = KIDX_W + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [255:0]      key,
   input  logic [1:0]        key_length,
   input  logic [KIDX_W-1:0] num_rounds,
   input  logic [KIDX_W-1:0] rd_addr,
   output logic [127:0]      rd_data,
   output logic              busy
);

   logic [127:0]      rk_mem [MAX_ROUND_KEYS];
   logic [127:0]      rd_data_ff;
   logic              busy_ff, busy_in;
   logic [WIDX_W-1:0] idx_ff, idx_in;
   logic [2:0]        col_ff, col_in;
   logic [7:0]        rc_ff, rc_in;
   logic [31:0]       win_ff [8];
   logic [31:0]       key_w [8];
   logic [3:0]        nk;
   logic [WIDX_W-1:0] total_last;
   logic [31:0]       tmp, new_word;
   logic              from_key;

   always_comb begin
      for (int j = 0; j < 8; j++) key_w[j] = key[255 - 32 * j -: 32];
      unique case (key_length)
         aesbc_pkg::KEY_LEN_128: nk = 4'd4;
         aesbc_pkg::KEY_LEN_192: nk = 4'd6;
         default:                nk = 4'd8;
      endcase
      total_last = {num_rounds + KIDX_W'(1), 2'b00} - WIDX_W'(1);
      from_key = idx_ff < WIDX_W'(nk);
      tmp = win_ff[0];
      if (col_ff == 3'd0) begin
         tmp = {aesbc_pkg::SBOX[win_ff[0][23:16]], aesbc_pkg::SBOX[win_ff[0][15:8]],
                aesbc_pkg::SBOX[win_ff[0][7:0]], aesbc_pkg::SBOX[win_ff[0][31:24]]}
               ^ {rc_ff, 24'h0};
      end else if (nk == 4'd8 && col_ff == 3'd4) begin
         tmp = {aesbc_pkg::SBOX[win_ff[0][31:24]], aesbc_pkg::SBOX[win_ff[0][23:16]],
                aesbc_pkg::SBOX[win_ff[0][15:8]], aesbc_pkg::SBOX[win_ff[0][7:0]]};
      end
      new_word = from_key ? key_w[idx_ff[2:0]] : (win_ff[3'(nk - 4'd1)] ^ tmp);

      busy_in = busy_ff;
      idx_in  = idx_ff;
      col_in  = col_ff;
      rc_in   = rc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         col_in  = '0;
         rc_in   = aesbc_pkg::RCON_FIRST;
      end else if (busy_ff) begin
         idx_in = idx_ff + WIDX_W'(1);
         col_in = (col_ff == 3'(nk - 4'd1)) ? 3'd0 : col_ff + 3'd1;
         if (!from_key && col_ff == 3'd0) rc_in = aesbc_pkg::xtime(rc_ff);
         if (idx_ff == total_last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         col_ff  <= '0;
         rc_ff   <= aesbc_pkg::RCON_FIRST;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         col_ff  <= col_in;
         rc_ff   <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         rk_mem[idx_ff[WIDX_W-1:2]][{~idx_ff[1:0], 5'b0} +: 32] <= new_word;
         win_ff[0] <= new_word;
         for (int j = 1; j < 8; j++) win_ff[j] <= win_ff[j-1];
      end
      rd_data_ff <= rk_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// ===== sv/aesbc_datapath.sv =====
// ============================================================================
// AES datapath
// State register, round logic, CBC chain register and result register.
// ============================================================================
module aesbc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  aesbc_pkg::ctrl_cmd_type cmd,
   input  logic                    opcode,
   input  logic                    first_block,
   input  logic [127:0]            block,
   input  logic                    chaining,
   input  logic [127:0]            iv,
   input  logic [127:0]            round_key,
   output logic [127:0]            result
);

   logic [127:0] state_ff, state_in;
   logic [127:0] blk_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] res_ff;
   logic         dec_ff;
   logic [127:0] chain_sel, rnd_out, final_out;

   always_comb begin
      chain_sel = (chaining && first_block) ? iv : chain_ff;
      rnd_out = dec_ff ? aesbc_pkg::dec_round(state_ff, round_key, cmd.skip_mix)
                       : aesbc_pkg::enc_round(state_ff, round_key, cmd.skip_mix);
      final_out = (dec_ff && chaining) ? (rnd_out ^ chain_ff) : rnd_out;
      state_in = state_ff;
      if (cmd.load) begin
         state_in = (chaining && opcode == aesbc_pkg::OP_ENCRYPT) ? (block ^ chain_sel) : block;
      end else if (cmd.add_key) begin
         state_in = state_ff ^ round_key;
      end else if (cmd.round) begin
         state_in = rnd_out;
      end
      chain_in = chain_ff;
      if (cmd.load) begin
         chain_in = chain_sel;
      end else if (cmd.finish && chaining) begin
         chain_in = dec_ff ? blk_ff : rnd_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.load) begin
         blk_ff <= block;
         dec_ff <= opcode;
      end
      if (cmd.finish) res_ff <= final_out;
   end

   assign result = res_ff;

endmodule

// ===== sv/aesbc_ctrl.sv =====
// ============================================================================
// AES controller
// Sequences one block: accept, initial key addition, rounds and hand-off.
// ============================================================================
module aesbc_ctrl #(
   parameter int MAX_ROUND_KEYS = 15,
   localparam int KIDX_W = $clog2(MAX_ROUND_KEYS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    opcode,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    ks_busy,
   input  logic [KIDX_W-1:0]       num_rounds,
   output logic [KIDX_W-1:0]       key_addr,
   output aesbc_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_INIT  = 2'd1;
   localparam logic [1:0] ST_ROUND = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [KIDX_W-1:0] cnt_ff, cnt_in;
   logic [KIDX_W-1:0] kaddr_ff, kaddr_in, kaddr_step;
   logic              dec_ff, dec_in;
   logic              accept, last;

   always_comb begin
      accept = state_ff == ST_IDLE && req_tvalid && !ks_busy;
      last   = cnt_ff == num_rounds - KIDX_W'(1);
      if (dec_ff) begin
         kaddr_step = (kaddr_ff != '0) ? kaddr_ff - KIDX_W'(1) : kaddr_ff;
      end else begin
         kaddr_step = (kaddr_ff < KIDX_W'(MAX_ROUND_KEYS - 1)) ? kaddr_ff + KIDX_W'(1) : kaddr_ff;
      end
      key_addr = kaddr_ff;
      if (state_ff == ST_IDLE) key_addr = opcode ? num_rounds : '0;

      cmd          = '0;
      cmd.load     = accept;
      cmd.add_key  = state_ff == ST_INIT;
      cmd.round    = state_ff == ST_ROUND;
      cmd.skip_mix = dec_ff ? (cnt_ff == '0) : last;
      cmd.finish   = state_ff == ST_ROUND && last;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      kaddr_in = kaddr_ff;
      dec_in   = dec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_INIT;
               cnt_in   = '0;
               dec_in   = opcode;
               kaddr_in = opcode ? num_rounds - KIDX_W'(1) : KIDX_W'(1);
            end
         end
         ST_INIT: begin
            state_in = ST_ROUND;
            kaddr_in = kaddr_step;
         end
         ST_ROUND: begin
            cnt_in   = cnt_ff + KIDX_W'(1);
            kaddr_in = kaddr_step;
            if (last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         kaddr_ff <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         kaddr_ff <= kaddr_in;
         dec_ff   <= dec_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE && !ks_busy;
   assign rsp_tvalid = state_ff == ST_OUT;

   a_accept_init: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_INIT) else $error("accepted block did not start");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      ks_busy |-> !req_tready) else $error("request taken during key expansion");
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid) else $error("result not presented after last round");
   a_round_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> cnt_ff < num_rounds) else $error("round count overrun");

endmodule

// ===== sv/aes_block_cipher_ecb_cbc.sv =====
// ============================================================================
// AES block cipher, ECB and CBC
// AES-128/192/256 encryption and decryption of one 128-bit block per request.
// ============================================================================
// After reset and after every write to a key word or to key_length the key
// schedule computes one round key word per cycle for all Nr+1 round keys,
// and no request is accepted during that time. A block then goes from
// acceptance to a valid response through the first key addition and then
// Nr rounds (Nr of 10, 12 or 14) run through a single shared round unit.
// The next request is accepted in the cycle after the response is taken.
module aes_block_cipher_ecb_cbc #(
   parameter int MAX_ROUND_KEYS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_low, block_high
   input  logic [1:0]   req_tuser,  // first_block, opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_low, result_high
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int KIDX_W = $clog2(MAX_ROUND_KEYS);

   logic [63:0]       key_ff [4];
   logic [63:0]       iv_high_ff, iv_low_ff;
   logic [1:0]        key_len_ff;
   logic              cbc_ff;
   logic              csr_write, ks_start, ks_busy;
   logic [KIDX_W-1:0] num_rounds, key_addr;
   logic [4:0]        nr_full;
   logic [127:0]      round_key, result;
   aesbc_pkg::ctrl_cmd_type cmd;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 4; j++) key_ff[j] <= '0;
         iv_high_ff <= '0;
         iv_low_ff  <= '0;
         key_len_ff <= '0;
         cbc_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            aesbc_pkg::REG_KEY_WORD_0: key_ff[0] <= csr_data;
            aesbc_pkg::REG_KEY_WORD_1: key_ff[1] <= csr_data;
            aesbc_pkg::REG_KEY_WORD_2: key_ff[2] <= csr_data;
            aesbc_pkg::REG_KEY_WORD_3: key_ff[3] <= csr_data;
            aesbc_pkg::REG_IV_HIGH:    iv_high_ff <= csr_data;
            aesbc_pkg::REG_IV_LOW:     iv_low_ff <= csr_data;
            aesbc_pkg::REG_KEY_LENGTH: key_len_ff <= csr_data[1:0];
            aesbc_pkg::REG_CHAINING:   cbc_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ks_start = csr_write && (csr_index == aesbc_pkg::REG_KEY_WORD_0 ||
                               csr_index == aesbc_pkg::REG_KEY_WORD_1 ||
                               csr_index == aesbc_pkg::REG_KEY_WORD_2 ||
                               csr_index == aesbc_pkg::REG_KEY_WORD_3 ||
                               csr_index == aesbc_pkg::REG_KEY_LENGTH);
      unique case (key_len_ff)
         aesbc_pkg::KEY_LEN_128: nr_full = 5'd10;
         aesbc_pkg::KEY_LEN_192: nr_full = 5'd12;
         default:                nr_full = 5'd14;
      endcase
      if (nr_full > 5'(MAX_ROUND_KEYS - 1)) nr_full = 5'(MAX_ROUND_KEYS - 1);
      num_rounds = KIDX_W'(nr_full);
   end

   aesbc_key_sched #(.MAX_ROUND_KEYS(MAX_ROUND_KEYS)) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (ks_start),
      .key        ({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .key_length (key_len_ff),
      .num_rounds (num_rounds),
      .rd_addr    (key_addr),
      .rd_data    (round_key),
      .busy       (ks_busy)
   );

   aesbc_ctrl #(.MAX_ROUND_KEYS(MAX_ROUND_KEYS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ks_busy    (ks_busy),
      .num_rounds (num_rounds),
      .key_addr   (key_addr),
      .cmd        (cmd)
   );

   aesbc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .opcode      (req_tuser[0]),
      .first_block (req_tuser[1]),
      .block       ({req_tdata[63:0], req_tdata[127:64]}),
      .chaining    (cbc_ff),
      .iv          ({iv_high_ff, iv_low_ff}),
      .round_key   (round_key),
      .result      (result)
   );

   assign rsp_tdata = {result[63:0], result[127:64]};

endmodule
